// ----- design/min_priority_queue_linear_scan_core_defines.svh -----
// assertion macros for the min priority queue core
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef MIN_PRIORITY_QUEUE_LINEAR_SCAN_CORE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_LINEAR_SCAN_CORE_DEFINES_SVH

// same-cycle implication
`define MPQ_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/mpq_pkg.sv -----
// shared types and codes for the min priority queue core
// no dependencies
package mpq_pkg;

  typedef logic signed [31:0] key_t;

  // request kinds
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_PEEK    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // key returned when there is no minimum to report
  localparam key_t KEY_NONE = -32'sd1;

  typedef struct packed {
    logic [1:0] kind;
    key_t       key_in;
  } in_item_t;

  typedef struct packed {
    key_t       key_out;
    logic [1:0] status;
  } out_item_t;

  // read data qualifiers from the scan sequencer to the min tracker
  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

// ----- design/min_priority_queue_linear_scan_core.sv -----
// Min priority queue over an unsorted key store, scanned by a sequencer.
// Insert, empty extract/peek and unused kinds go from idle straight to the result state;
// extract/peek with held keys first scan the key memory, one read per cycle, then commit.
// A new request is taken only once the result has moved into the output register.
// Reset clears the fill count and control; the key memory is not cleared.
// Extract fills the vacated slot with the last held key.
`include "min_priority_queue_linear_scan_core_defines.svh"
module min_priority_queue_linear_scan_core import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_RESULT
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             issue_q, issue_d;
  logic             rvalid_q, rvalid_d;
  logic             rlast_q, rlast_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic [1:0]       op_q, op_d;
  key_t             last_key_q, last_key_d;
  out_item_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             in_xfer;
  logic             out_load;
  logic [AddrW-1:0] last_idx;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  key_t             mem_wdata;
  logic             mem_re;
  key_t             mem_rdata;
  scan_ctl_t        scan_ctl;
  key_t             min_key;
  logic [AddrW-1:0] min_pos;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign last_idx   = AddrW'(fill_q - CntW'(1));
  assign out_load   = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  // key memory
  mpq_store #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // minimum tracker fed by the read data
  assign scan_ctl.valid = rvalid_q;
  assign scan_ctl.first = (raddr_q == '0);

  mpq_min_track #(
    .AddrW (AddrW)
  ) u_min (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .key_i     (mem_rdata),
    .pos_i     (raddr_q),
    .min_key_o (min_key),
    .min_pos_o (min_pos)
  );

  // sequencer next state and memory requests
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    rvalid_d    = 1'b0;
    rlast_d     = rlast_q;
    raddr_d     = raddr_q;
    op_d        = op_q;
    last_key_d  = last_key_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = min_pos;
    mem_wdata   = last_key_q;
    mem_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d          = in_i.kind;
          res_d.key_out = KEY_NONE;
          res_d.status  = ST_OK;
          state_d       = S_RESULT;
          case (in_i.kind) inside
            KIND_INSERT: begin
              if (fill_q == FullCnt) begin
                res_d.status = ST_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(fill_q);
                mem_wdata = in_i.key_in;
                fill_d    = fill_q + CntW'(1);
              end
            end
            KIND_EXTRACT, KIND_PEEK: begin
              if (fill_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                idx_d   = '0;
                issue_d = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_d.status = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue one read a cycle up to the last held key
        if (issue_q) begin
          mem_re   = 1'b1;
          rvalid_d = 1'b1;
          raddr_d  = idx_q;
          rlast_d  = (idx_q == last_idx);
          idx_d    = idx_q + AddrW'(1);
          if (idx_q == last_idx) begin
            issue_d = 1'b0;
          end
        end
        // last read data arrives: remember it to fill the gap
        if (rvalid_q && rlast_q) begin
          last_key_d = mem_rdata;
          state_d    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        res_d.key_out = min_key;
        res_d.status  = ST_OK;
        if (op_q == KIND_EXTRACT) begin
          mem_we = 1'b1;
          fill_d = fill_q - CntW'(1);
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // output register
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      issue_q     <= 1'b0;
      rvalid_q    <= 1'b0;
      rlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      issue_q     <= issue_d;
      rvalid_q    <= rvalid_d;
      rlast_q     <= rlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    raddr_q    <= raddr_d;
    op_q       <= op_d;
    last_key_q <= last_key_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  `MPQ_ASSERT(a_fill_bound, 1'b1, fill_q <= FullCnt, "fill count above capacity")
  `MPQ_ASSERT(a_no_write_in_scan, mem_we, !issue_q && !rvalid_q, "write while scan reads in flight")
  `MPQ_ASSERT_NEXT(a_insert_grows, in_xfer && (in_i.kind == KIND_INSERT) && (fill_q != FullCnt), fill_q == $past(fill_q) + CntW'(1), "insert did not grow fill count")

endmodule

// ----- design/mpq_store.sv -----
// key storage: one write port, one read port, registered read data
// depends on mpq_pkg for the key type
module mpq_store import mpq_pkg::*; #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  key_t             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output key_t             rdata_o
);

  key_t mem_q [Depth];
  key_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/mpq_min_track.sv -----
// running minimum over the read data of a scan, lowest position wins ties
// depends on mpq_pkg for the key and scan control types
module mpq_min_track import mpq_pkg::*; #(
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_ctl_t        ctl_i,
  input  key_t             key_i,
  input  logic [AddrW-1:0] pos_i,
  output key_t             min_key_o,
  output logic [AddrW-1:0] min_pos_o
);

  key_t             min_key_q;
  logic [AddrW-1:0] min_pos_q;
  logic             take;

  // strict less-than keeps the earlier position on equal keys
  assign take = ctl_i.valid && (ctl_i.first || (key_i < min_key_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pos_q <= '0;
    end else if (take) begin
      min_pos_q <= pos_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      min_key_q <= key_i;
    end
  end

  assign min_key_o = min_key_q;
  assign min_pos_o = min_pos_q;

endmodule

// ----- test/tb_min_priority_queue_linear_scan_core.sv -----
// testbench for the min priority queue core: directed and random requests,
// predicted results checked in order. Depends on mpq_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_min_priority_queue_linear_scan_core;
  import mpq_pkg::*;

  localparam int unsigned QCAP        = 128;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;

  // request kind that the core ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  typedef enum int unsigned {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  in_item_t  in_req = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_res;

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  out_item_t oldest_result;

  // shadow of the queue contents
  key_t       held_keys[QCAP];
  logic [7:0] held_count = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_gen = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  min_priority_queue_linear_scan_core #(
    .CAPACITY(QCAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_res)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // applies one request to the shadow queue and returns the result it must give
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t   res;
    int unsigned best;
    res.key_out = KEY_NONE;
    res.status  = ST_OK;
    case (req.kind)
      KIND_INSERT: begin
        if (held_count >= QCAP) begin
          res.status = ST_OVERFLOW;
        end else begin
          held_keys[held_count] = req.key_in;
          held_count = held_count + 1'b1;
        end
      end
      KIND_EXTRACT, KIND_PEEK: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < held_count; i++) begin
            if (held_keys[i] < held_keys[best]) best = i;
          end
          res.key_out = held_keys[best];
          // close the gap; only the values matter, not their positions
          if (req.kind == KIND_EXTRACT) begin
            for (int i = best; i + 1 < held_count; i++) held_keys[i] = held_keys[i + 1];
            held_count = held_count - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // key mix: extremes, small clustered values for ties, and full range
  function automatic key_t pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return KEY_MAX;
    if (roll < 10) return KEY_MIN;
    if (roll < 15) return key_t'($urandom_range(2)) - 1;
    if (roll < 45) return key_t'($urandom_range(16)) - 8;
    return key_t'($urandom);
  endfunction

  task automatic queue_request(input logic [1:0] kind, input key_t key);
    in_item_t req;
    req.kind   = kind;
    req.key_in = key;
    pending_reqs.push_back(req);
  endtask

  // fill past capacity, then drain past empty with a few peeks mixed in
  task automatic queue_fill_and_drain();
    int unsigned removed;
    repeat (QCAP + 3) queue_request(KIND_INSERT, pick_key());
    removed = 0;
    while (removed < QCAP + 2) begin
      if ($urandom_range(99) < 15) begin
        queue_request(KIND_PEEK, key_t'($urandom));
      end else begin
        queue_request(KIND_EXTRACT, key_t'($urandom));
        removed++;
      end
    end
  endtask

  // segments that lean toward filling, draining or an even mix
  task automatic queue_random_mix(input int unsigned n_items);
    int unsigned left, seg, roll, ins_pct, ext_pct, peek_pct;
    seg_mode_e   mode;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(40, 8);
      if (seg > left) seg = left;
      left -= seg;
      mode = seg_mode_e'($urandom_range(2));
      case (mode)
        SEG_FILL: begin
          ins_pct = 75; ext_pct = 12; peek_pct = 10;
        end
        SEG_DRAIN: begin
          ins_pct = 20; ext_pct = 55; peek_pct = 22;
        end
        default: begin
          ins_pct = 45; ext_pct = 35; peek_pct = 17;
        end
      endcase
      repeat (seg) begin
        roll = $urandom_range(99);
        if (roll < ins_pct) queue_request(KIND_INSERT, pick_key());
        else if (roll < ins_pct + ext_pct) queue_request(KIND_EXTRACT, key_t'($urandom));
        else if (roll < ins_pct + ext_pct + peek_pct) queue_request(KIND_PEEK, key_t'($urandom));
        else queue_request(KIND_UNUSED, key_t'($urandom));
      end
    end
  endtask

  // sender holds back until every result is in
  task automatic wait_all_done();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input int expv, input int gotv);
    $error("%s mismatch: expected %0d, got %0d", field, expv, gotv);
    fail_count++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) expected_results.push_back(apply_request(in_req));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req   <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: key_out %0d status %0d",
                 out_res.key_out, out_res.status);
          fail_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_res.key_out !== oldest_result.key_out)
            report_mismatch("key_out", oldest_result.key_out, out_res.key_out);
          if (out_res.status !== oldest_result.status)
            report_mismatch("status", oldest_result.status, out_res.status);
        end
      end
      // long hold-off requested by the sequence, counted here
      if (hold_gen != hold_seen) begin
        hold_seen <= hold_gen;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= (hold_gen != hold_seen) || (hold_left > 1) ||
                   ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty queue, extremes, ties, ignored kind, overflow later
    queue_request(KIND_PEEK, KEY_MIN);
    queue_request(KIND_EXTRACT, KEY_MAX);
    queue_request(KIND_UNUSED, KEY_MAX);
    queue_request(KIND_INSERT, KEY_MAX);
    queue_request(KIND_INSERT, KEY_MIN);
    queue_request(KIND_INSERT, 0);
    queue_request(KIND_INSERT, -1);
    queue_request(KIND_INSERT, 1);
    queue_request(KIND_INSERT, -1);
    queue_request(KIND_PEEK, 0);
    queue_request(KIND_EXTRACT, KEY_MAX);
    queue_request(KIND_EXTRACT, 0);
    queue_request(KIND_PEEK, KEY_MIN);
    queue_request(KIND_EXTRACT, 0);
    queue_request(KIND_UNUSED, KEY_MIN);
    queue_request(KIND_EXTRACT, 0);
    queue_request(KIND_EXTRACT, -1);
    queue_request(KIND_EXTRACT, 0);
    queue_request(KIND_EXTRACT, 0);
    queue_request(KIND_INSERT, 32'sh5555_5555);
    queue_request(KIND_INSERT, 32'shAAAA_AAAA);
    queue_request(KIND_EXTRACT, 32'sh5555_5555);
    queue_request(KIND_EXTRACT, 32'shAAAA_AAAA);
    wait_all_done();

    // no idling, with a long receiver hold-off to back up the input
    hold_gen++;
    queue_random_mix(150);
    queue_fill_and_drain();
    wait_all_done();

    // sender idle
    send_idle_pct = 56;
    queue_random_mix(180);
    wait_all_done();

    // receiver stalling
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    queue_fill_and_drain();
    queue_random_mix(120);
    wait_all_done();

    // both sides idling, another hold-off
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    hold_gen++;
    queue_random_mix(150);
    wait_all_done();

    repeat (QCAP + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/mpq_pkg.sv
design/mpq_store.sv
design/mpq_min_track.sv
design/min_priority_queue_linear_scan_core.sv
test/tb_min_priority_queue_linear_scan_core.sv
